FILE: hw/rtl/rgb_conv3x3_divide_clamp_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 convolution filter
// Shared concurrent checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef RGB_CONV3X3_DIVIDE_CLAMP_ASSERT_SVH
`define RGB_CONV3X3_DIVIDE_CLAMP_ASSERT_SVH

// Implication checked at every edge outside reset.
`define RCDC_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RCDC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/rcdc_pkg.sv
// ----------------------------------------------------------------------------
// rcdc_pkg
// Types and constants shared by the convolution filter modules.
// ----------------------------------------------------------------------------
package rcdc_pkg;

  localparam int unsigned CoordW = 11;
  localparam int unsigned PixW   = 24;
  localparam int unsigned ProdW  = 25;
  localparam int unsigned SumW   = 29;
  localparam int unsigned QueueDepth = 4;

  localparam logic [2:0] RegKTop = 3'd0;
  localparam logic [2:0] RegKMid = 3'd1;
  localparam logic [2:0] RegKBot = 3'd2;
  localparam logic [2:0] RegDiv  = 3'd3;
  localparam logic [2:0] RegW    = 3'd4;
  localparam logic [2:0] RegH    = 3'd5;

  // One classified result request from the front to the back.
  typedef struct packed {
    logic                    conv;
    logic                    pass;
    logic [PixW-1:0]         pix;
    logic [8:0][PixW-1:0]    win;
    logic [CoordW-1:0]       col;
    logic [CoordW-1:0]       row;
    logic                    last;
  } req_t;

  // Status of the front part toward the top level.
  typedef struct packed {
    logic busy;
  } front_stat_t;

endpackage

FILE: hw/rtl/rcdc_front.sv
// ----------------------------------------------------------------------------
// rcdc_front
// Accepts pixels, updates line stores and window, and issues result requests.
// ----------------------------------------------------------------------------
module rcdc_front #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_blue,
  input  logic [7:0]                 in_green,
  input  logic [7:0]                 in_red,
  input  logic [11:0]                image_width,
  input  logic [11:0]                image_height,
  input  logic                       geom_wr,
  output rcdc_pkg::req_t             req,
  output logic                       req_valid,
  input  logic                       req_ready,
  output rcdc_pkg::front_stat_t      stat
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned XW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  logic [rcdc_pkg::PixW-1:0] mem_up [MAX_WIDTH];
  logic [rcdc_pkg::PixW-1:0] mem_lo [MAX_WIDTH];
  logic [rcdc_pkg::PixW-1:0] rd_up, rd_lo, pix;
  logic [8:0][rcdc_pkg::PixW-1:0] win;
  logic [XW-1:0] cnt_x, x;
  logic [YW-1:0] cnt_y, y;
  logic [XW-1:0] w;
  logic [YW-1:0] h;
  logic [3:0] pend;
  logic       tiny;
  logic [1:0] sel;
  logic [3:0] pend_after;

  always_comb begin
    if (image_width == 12'd0) w = XW'(1);
    else if (32'(image_width) > MAX_WIDTH) w = XW'(MAX_WIDTH);
    else w = XW'(image_width);
    if (image_height == 12'd0) h = YW'(1);
    else if (32'(image_height) > MAX_HEIGHT) h = YW'(MAX_HEIGHT);
    else h = YW'(image_height);
  end

  assign tiny = (32'(w) < 3) || (32'(h) < 3);
  assign in_ready = (state == S_IDLE);
  assign stat.busy = (state != S_IDLE);
  assign req_valid = (state == S_EMIT) && (pend != 4'd0);

  always_comb begin
    sel = 2'd0;
    if (pend[0]) sel = 2'd0;
    else if (pend[1]) sel = 2'd1;
    else if (pend[2]) sel = 2'd2;
    else sel = 2'd3;
    pend_after = pend;
    pend_after[sel] = 1'b0;
  end

  always_comb begin
    req.conv = 1'b0;
    req.pass = tiny;
    req.pix  = pix;
    req.win  = win;
    req.last = (pend_after == 4'd0);
    req.col  = rcdc_pkg::CoordW'(x);
    req.row  = rcdc_pkg::CoordW'(y);
    if (!tiny) begin
      case (sel)
        2'd0: begin
          req.conv = (32'(x) >= 2) && (32'(y) >= 2);
          req.col  = rcdc_pkg::CoordW'(x - XW'(1));
          req.row  = rcdc_pkg::CoordW'(y - YW'(1));
        end
        2'd1: begin
          req.col = rcdc_pkg::CoordW'(w - XW'(1));
          req.row = rcdc_pkg::CoordW'(y - YW'(1));
        end
        2'd2: begin
          req.col = rcdc_pkg::CoordW'(x - XW'(1));
          req.row = rcdc_pkg::CoordW'(h - YW'(1));
        end
        default: begin
          req.col = rcdc_pkg::CoordW'(w - XW'(1));
          req.row = rcdc_pkg::CoordW'(h - YW'(1));
        end
      endcase
    end
  end

  always_comb begin
    x = (cnt_x >= w) ? '0 : cnt_x;
    y = (cnt_y >= h) ? '0 : cnt_y;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !tiny) begin
      rd_up <= mem_up[x[AW-1:0]];
      rd_lo <= mem_lo[x[AW-1:0]];
    end
    if (state == S_READ) begin
      mem_up[x[AW-1:0]] <= rd_lo;
      mem_lo[x[AW-1:0]] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt_x <= '0;
      cnt_y <= '0;
      pend  <= '0;
      win   <= '0;
    end else if (geom_wr) begin
      cnt_x <= '0;
      cnt_y <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pix <= {in_red, in_green, in_blue};
            if (tiny) begin
              pend  <= 4'b0001;
              state <= S_EMIT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          for (int r = 0; r < 3; r++) begin
            win[r*3+0] <= win[r*3+1];
            win[r*3+1] <= win[r*3+2];
          end
          win[2] <= rd_up;
          win[5] <= rd_lo;
          win[8] <= pix;
          pend[0] <= (32'(y) >= 1) && (32'(x) >= 1);
          pend[1] <= (32'(y) >= 1) && (x == w - XW'(1));
          pend[2] <= (y == h - YW'(1)) && (32'(x) >= 1);
          pend[3] <= (y == h - YW'(1)) && (x == w - XW'(1));
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (pend == 4'd0 || req_ready) begin
            if (pend == 4'd0 || pend_after == 4'd0) begin
              state <= S_IDLE;
              pend  <= '0;
              if (x + XW'(1) >= w) begin
                cnt_x <= '0;
                cnt_y <= (y + YW'(1) >= h) ? '0 : y + YW'(1);
              end else begin
                cnt_x <= x + XW'(1);
                cnt_y <= y;
              end
            end else begin
              pend <= pend_after;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rcdc_queue.sv
// ----------------------------------------------------------------------------
// rcdc_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module rcdc_queue (
  input  logic           clk,
  input  logic           rst,
  input  rcdc_pkg::req_t wr_data,
  input  logic           wr_valid,
  output logic           wr_ready,
  output rcdc_pkg::req_t rd_data,
  output logic           rd_valid,
  input  logic           rd_ready
);

  localparam int unsigned PW = $clog2(rcdc_pkg::QueueDepth);

  rcdc_pkg::req_t slots [rcdc_pkg::QueueDepth];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   cnt;
  logic          do_wr, do_rd;

  assign wr_ready = (32'(cnt) < rcdc_pkg::QueueDepth);
  assign rd_valid = (cnt != '0);
  assign rd_data  = slots[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) slots[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= wp + PW'(1);
      if (do_rd) rp <= rp + PW'(1);
      cnt <= cnt + (PW+1)'(do_wr) - (PW+1)'(do_rd);
    end
  end

endmodule

FILE: hw/rtl/rcdc_back.sv
// ----------------------------------------------------------------------------
// rcdc_back
// Convolves one request, divides with a shared serial divider and clamps.
// ----------------------------------------------------------------------------
module rcdc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rcdc_pkg::req_t        req,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [47:0]           k_top,
  input  logic [47:0]           k_mid,
  input  logic [47:0]           k_bot,
  input  logic signed [15:0]    divisor,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_green,
  output logic [7:0]            out_red,
  output logic [10:0]           out_col,
  output logic [10:0]           out_row,
  output logic                  run_last
);

  localparam int unsigned SW = rcdc_pkg::SumW;
  localparam int unsigned DW = 16;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MAC  = 6'b000010,
    B_DIVS = 6'b000100,
    B_DIV  = 6'b001000,
    B_FIN  = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_t;

  bstate_t state;
  rcdc_pkg::req_t cur;
  logic [3:0] tap;
  logic [1:0] ch;
  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] prod;
  logic [143:0] kall;
  logic signed [15:0] coef;
  logic [7:0] pv;
  logic [SW-1:0] num_abs, quo;
  logic [DW:0]   rem;
  logic [DW-1:0] den_abs;
  logic          neg;
  logic [4:0]    bit_i;
  logic [DW:0]   rem_sh;
  logic [7:0]    res [3];
  logic [7:0]    clamped;
  logic signed [SW:0] qs;

  assign kall = {k_bot, k_mid, k_top};
  assign coef = kall[tap*16 +: 16];
  assign pv   = cur.win[tap][ch*8 +: 8];
  assign req_ready = (state == B_IDLE);
  assign out_valid = (state == B_OUT);
  assign rem_sh = {rem[DW-1:0], num_abs[SW-1]};

  always_comb begin
    qs = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (qs < 0) clamped = 8'd0;
    else if (qs > 255) clamped = 8'd255;
    else clamped = qs[7:0];
  end

  always_ff @(posedge clk) begin
    prod <= SW'($signed({1'b0, pv}) * coef);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (req_valid) begin
            cur <= req;
            ch  <= 2'd0;
            tap <= 4'd0;
            acc <= '0;
            if (req.conv) state <= B_MAC;
            else begin
              res[0] <= req.pass ? req.pix[7:0]   : 8'd0;
              res[1] <= req.pass ? req.pix[15:8]  : 8'd0;
              res[2] <= req.pass ? req.pix[23:16] : 8'd0;
              state  <= B_OUT;
            end
          end
        end
        // Product of tap t is registered and ready in the next state; accumulate with lag.
        B_MAC: begin
          if (tap != 4'd0) acc <= acc + prod;
          if (tap == 4'd9) state <= B_DIVS;
          else tap <= tap + 4'd1;
        end
        B_DIVS: begin
          neg     <= acc[SW-1] ^ divisor[15];
          num_abs <= acc[SW-1] ? SW'(-acc) : acc;
          den_abs <= (divisor == 16'sd0) ? 16'd1 :
                     (divisor[15] ? DW'(-divisor) : DW'(divisor));
          rem     <= '0;
          quo     <= '0;
          bit_i   <= 5'(SW);
          state   <= B_DIV;
        end
        B_DIV: begin
          num_abs <= num_abs << 1;
          if (rem_sh >= {1'b0, den_abs}) begin
            rem <= rem_sh - {1'b0, den_abs};
            quo <= {quo[SW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[SW-2:0], 1'b0};
          end
          bit_i <= bit_i - 5'd1;
          if (bit_i == 5'd1) state <= B_FIN;
        end
        B_FIN: begin
          res[ch] <= clamped;
          if (ch == 2'd2) state <= B_OUT;
          else begin
            ch <= ch + 2'd1;
            tap <= 4'd0;
            acc <= '0;
            state <= B_MAC;
          end
        end
        B_OUT: begin
          if (out_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign out_blue  = res[0];
  assign out_green = res[1];
  assign out_red   = res[2];
  assign out_col   = cur.col;
  assign out_row   = cur.row;
  assign run_last  = cur.last;

endmodule

FILE: hw/rtl/rgb_conv3x3_divide_clamp.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_divide_clamp
// 3x3 RGB convolution filter with divide and clamp.
// ----------------------------------------------------------------------------
// One pixel is taken at a time. The front reads the line stores as it takes a
// pixel, then writes them back and shifts the window, then issues the results
// of the pixel one at a time (up to four results, or none), and pass-through
// pixels skip the line store states. Results queue to the back, which for each
// channel of an interior pixel runs the multiply-accumulate steps (including
// the product register lag), a setup step, a 29-step serial divider and a store
// step, and for border or pass-through results only presents the output; the
// output can stall. The back takes no new request until its output is taken,
// so the serial divider sets the pixel rate. Line stores start undefined.
`include "rgb_conv3x3_divide_clamp_assert.svh"

module rgb_conv3x3_divide_clamp #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [10:0] out_col,
  output logic [10:0] out_row,
  output logic        run_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [47:0] k_top, k_mid, k_bot;
  logic signed [15:0] divisor;
  logic [11:0] image_width, image_height;
  logic geom_wr;
  rcdc_pkg::req_t f_req, q_req;
  logic f_valid, f_ready, q_valid, q_ready;
  rcdc_pkg::front_stat_t fstat;

  assign geom_wr = cfg_we && (cfg_index == rcdc_pkg::RegW || cfg_index == rcdc_pkg::RegH);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_top <= '0;
      k_mid <= 48'd65536;
      k_bot <= '0;
      divisor <= 16'sd1;
      image_width <= 12'd640;
      image_height <= 12'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        rcdc_pkg::RegKTop: k_top <= cfg_data;
        rcdc_pkg::RegKMid: k_mid <= cfg_data;
        rcdc_pkg::RegKBot: k_bot <= cfg_data;
        rcdc_pkg::RegDiv:  divisor <= $signed(cfg_data[15:0]);
        rcdc_pkg::RegW:    image_width <= cfg_data[11:0];
        rcdc_pkg::RegH:    image_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  rcdc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_blue, .in_green, .in_red,
    .image_width, .image_height, .geom_wr,
    .req(f_req), .req_valid(f_valid), .req_ready(f_ready), .stat(fstat)
  );

  rcdc_queue u_queue (
    .clk, .rst, .wr_data(f_req), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_req), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  rcdc_back u_back (
    .clk, .rst, .req(q_req), .req_valid(q_valid), .req_ready(q_ready),
    .k_top, .k_mid, .k_bot, .divisor,
    .out_valid, .out_ready, .out_blue, .out_green, .out_red,
    .out_col, .out_row, .run_last
  );

  `RCDC_ASSERT_IMPL(a_busy_no_ready, clk, rst, fstat.busy, !in_ready)
  `RCDC_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready && !cfg_we, fstat.busy)
  `RCDC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_col))

endmodule

FILE: bench/rgb_conv3x3_divide_clamp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the 3x3 RGB convolution filter
// Streams small frames through the filter under several kernel, divisor and
// geometry settings, with random gaps on both handshakes, and checks every
// result pixel and its coordinates against a predictor kept in the bench.
// ----------------------------------------------------------------------------
module rgb_conv3x3_divide_clamp_tb;

  localparam int CycleLimit = 1000000;
  localparam int TargetPixels = 450;
  localparam int SettleCycles = 200;

  typedef struct packed {
    bit [7:0]  blue;
    bit [7:0]  green;
    bit [7:0]  red;
    bit [10:0] col;
    bit [10:0] row;
    bit        last;
  } conv_pixel_t;

  class conv_scoreboard;
    bit [47:0]   krow [3];
    bit [15:0]   divisor;
    bit [11:0]   width_reg;
    bit [11:0]   height_reg;
    bit [23:0]   upper_line [2048];
    bit [23:0]   lower_line [2048];
    bit [23:0]   win [3][3];
    int          col_cnt;
    int          row_cnt;
    conv_pixel_t expected_pixels [$];
    int          errors;

    function new();
      krow[0] = 48'd0;
      krow[1] = 48'd65536;
      krow[2] = 48'd0;
      divisor = 16'd1;
      width_reg = 12'd640;
      height_reg = 12'd480;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
      foreach (win[r, c]) win[r][c] = '0;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, bit [47:0] data);
      case (idx)
        rcdc_pkg::RegKTop: krow[0] = data;
        rcdc_pkg::RegKMid: krow[1] = data;
        rcdc_pkg::RegKBot: krow[2] = data;
        rcdc_pkg::RegDiv:  divisor = data[15:0];
        rcdc_pkg::RegW: begin
          width_reg = data[11:0];
          col_cnt = 0;
          row_cnt = 0;
        end
        rcdc_pkg::RegH: begin
          height_reg = data[11:0];
          col_cnt = 0;
          row_cnt = 0;
        end
        default: ;
      endcase
    endfunction

    function int eff_dim(bit [11:0] v);
      if (v == 0) return 1;
      return (v > 2048) ? 2048 : int'(v);
    endfunction

    function bit [7:0] filter_channel(int sh);
      longint acc;
      longint dv;
      longint q;
      acc = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          acc += longint'(win[r][c][sh +: 8]) * longint'($signed(krow[r][16*c +: 16]));
      dv = (divisor == 0) ? 1 : longint'($signed(divisor));
      q = acc / dv;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return q[7:0];
    endfunction

    function void push(bit [23:0] pix, int c, int r);
      conv_pixel_t p;
      p.blue = pix[7:0];
      p.green = pix[15:8];
      p.red = pix[23:16];
      p.col = c[10:0];
      p.row = r[10:0];
      p.last = 1'b0;
      expected_pixels.push_back(p);
    endfunction

    // Works out the results that one accepted pixel causes.
    function void note_pixel(bit [7:0] b, bit [7:0] g, bit [7:0] r);
      int w;
      int h;
      int x;
      int y;
      int n;
      bit [23:0] pix;
      bit [23:0] a2;
      bit [23:0] a1;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      x = (col_cnt >= w) ? 0 : col_cnt;
      y = (row_cnt >= h) ? 0 : row_cnt;
      pix = {r, g, b};
      n = expected_pixels.size();
      if (w < 3 || h < 3) begin
        push(pix, x, y);
      end else begin
        a2 = upper_line[x];
        a1 = lower_line[x];
        upper_line[x] = a1;
        lower_line[x] = pix;
        for (int i = 0; i < 3; i++) begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
        win[0][2] = a2;
        win[1][2] = a1;
        win[2][2] = pix;
        if (y >= 1 && x >= 1)
          push((x >= 2 && y >= 2) ?
               {filter_channel(16), filter_channel(8), filter_channel(0)} : 24'd0,
               x - 1, y - 1);
        if (y >= 1 && x == w - 1) push(24'd0, w - 1, y - 1);
        if (y == h - 1 && x >= 1) push(24'd0, x - 1, h - 1);
        if (y == h - 1 && x == w - 1) push(24'd0, w - 1, h - 1);
      end
      if (expected_pixels.size() > n)
        expected_pixels[expected_pixels.size() - 1].last = 1'b1;
      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) y = 0;
      end
      col_cnt = x;
      row_cnt = y;
    endfunction

    function void check_result(conv_pixel_t got);
      conv_pixel_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: col %0d row %0d rgb %0d/%0d/%0d",
                   got.col, got.row, got.red, got.green, got.blue);
        return;
      end
      want = expected_pixels.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want c%0d r%0d rgb %0d/%0d/%0d l%0b got c%0d r%0d rgb %0d/%0d/%0d l%0b",
                   want.col, want.row, want.red, want.green, want.blue, want.last,
                   got.col, got.row, got.red, got.green, got.blue, got.last);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_blue;
  logic [7:0]  in_green;
  logic [7:0]  in_red;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [10:0] out_col;
  logic [10:0] out_row;
  logic        run_last;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  conv_scoreboard board;
  int  cycles;
  int  pixels_sent;
  bit  eager;
  bit  hold_req;

  rgb_conv3x3_divide_clamp DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .out_col(out_col), .out_row(out_row), .run_last(run_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin : result_sink
    int gap;
    conv_pixel_t got;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        gap = 300;
        hold_req = 1'b0;
      end else if (eager) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 7);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.blue = out_blue;
      got.green = out_green;
      got.red = out_red;
      got.col = out_col;
      got.row = out_row;
      got.last = run_last;
      board.check_result(got);
    end
  end

  // The final clock wait keeps back-to-back writes from driving the enable twice
  // in one time step.
  task automatic write_reg(logic [2:0] idx, bit [47:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    board.set_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(bit [7:0] b, bit [7:0] g, bit [7:0] r);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(b, g, r);
    pixels_sent++;
  endtask

  task automatic send_stream(int count);
    bit [7:0] ch [3];
    for (int i = 0; i < count; i++) begin
      foreach (ch[k]) begin
        case ($urandom_range(0, 5))
          0: ch[k] = 8'd0;
          1: ch[k] = 8'd255;
          default: ch[k] = 8'($urandom_range(0, 255));
        endcase
      end
      send_pixel(ch[0], ch[1], ch[2]);
    end
  endtask

  // Called right after the last accepted pixel, so the request is withdrawn
  // before the block can take it a second time.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic bit [15:0] random_coef();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($signed($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  function automatic bit [15:0] random_divisor();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'($urandom_range(0, 65535));
      4: return 16'($signed($urandom_range(0, 8)) - 9);
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  initial begin
    bit [47:0] junk;
    int w;
    int h;
    int frames;
    bit hold_done;
    rst = 1'b1;
    in_valid = 1'b0;
    in_blue = '0;
    in_green = '0;
    in_red = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    pixels_sent = 0;
    eager = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry is a large frame: the first row causes no results.
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    wait_idle();

    // Identity kernel on a 3x3 frame with extreme values.
    write_reg(rcdc_pkg::RegW, 48'd3);
    write_reg(rcdc_pkg::RegH, 48'd3);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd0 : 8'd255, 8'(i * 31));
    wait_idle();

    // Edge detector with a zero divisor, then two ignored register indices.
    write_reg(rcdc_pkg::RegKTop, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    write_reg(rcdc_pkg::RegKMid, {16'hFFFF, 16'd8, 16'hFFFF});
    write_reg(rcdc_pkg::RegKBot, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    write_reg(rcdc_pkg::RegDiv, 48'd0);
    write_reg(3'd6, 48'hFFFF_FFFF_FFFF);
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
    send_stream(9);
    wait_idle();

    // Zero width acts as one: pass-through; oversize width saturates.
    write_reg(rcdc_pkg::RegW, 48'd0);
    write_reg(rcdc_pkg::RegH, 48'd5);
    send_stream(3);
    wait_idle();
    write_reg(rcdc_pkg::RegW, 48'hFFF);
    write_reg(rcdc_pkg::RegH, 48'd2);
    send_stream(3);
    wait_idle();

    while (pixels_sent < TargetPixels) begin
      eager = ($urandom_range(0, 3) == 0);
      write_reg(rcdc_pkg::RegKTop, {random_coef(), random_coef(), random_coef()});
      write_reg(rcdc_pkg::RegKMid, {random_coef(), random_coef(), random_coef()});
      write_reg(rcdc_pkg::RegKBot, {random_coef(), random_coef(), random_coef()});
      junk = 48'({$urandom(), $urandom()});
      write_reg(rcdc_pkg::RegDiv, {junk[47:16], random_divisor()});
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: begin w = $urandom_range(0, 2); h = $urandom_range(0, 6); end
          1: begin w = $urandom_range(3, 6); h = $urandom_range(0, 2); end
          2: begin w = 2048; h = 2048; end
          default: begin w = $urandom_range(3, 8); h = $urandom_range(3, 6); end
        endcase
        junk = 48'({$urandom(), $urandom()});
        write_reg(rcdc_pkg::RegW, {junk[47:12], 12'(w)});
        write_reg(rcdc_pkg::RegH, {junk[47:12], 12'(h)});
      end
      if (!hold_done && pixels_sent > 150) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
        eager = 1'b1;
      end
      w = board.eff_dim(board.width_reg);
      h = board.eff_dim(board.height_reg);
      frames = $urandom_range(1, 2);
      if (w * h > 64)
        send_stream($urandom_range(1, 6));
      else if ($urandom_range(0, 4) == 0)
        send_stream($urandom_range(1, w * h));
      else
        send_stream(frames * w * h);
      wait_idle();
    end

    repeat (SettleCycles) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
